// ----- design/assert_macros.svh -----
// assertion macros used by the decoder rtl
// no dependencies; include once per file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, quiet while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequence checked in the next cycle, quiet while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/vdp_pkg.sv -----
// package of the varint delta posting decoder: payload structs, status codes, constants
// no dependencies
`default_nettype none

package vdp_pkg;

  // default width of the record id arithmetic
  localparam int unsigned IdWidthDefault = 32;

  // varint framing
  localparam int unsigned StepWidth  = 4;
  localparam logic [StepWidth-1:0] MaxSteps = 4'd9;  // shift 63 reached
  localparam logic [6:0] ShiftStep   = 7'd7;
  localparam int unsigned ShiftWidth = 7;

  typedef enum logic [2:0] {
    StRunning   = 3'd0,
    StOk        = 3'd1,
    StTruncated = 3'd2,
    StTooLarge  = 3'd3,
    StMismatch  = 3'd4,
    StDiscard   = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] expected_count;
  } in_item_t;

  typedef struct packed {
    logic        id_valid;
    logic [31:0] rec_id;
    logic        list_end;
    status_e     status;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/varint_delta_posting_decoder.sv -----
// varint delta posting decoder, top level
// depends on vdp_pkg and assert_macros.svh
// -----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o | vdp_pkg::in_item_t
// out     | output    | out_valid_o/out_stall_i | vdp_pkg::out_item_t
//
// one byte per cycle unless the input stalls: each accepted byte gives one result in the
// next cycle, set by the single pass (payload or, id add, count compare) into the result register.
// rst_ni clears the decode state and marks the next byte as a list start.
// the input stalls only while a result waits in the result register and the
// output side stalls; the decode state advances only on an accepted byte.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module varint_delta_posting_decoder #(
  parameter int unsigned ID_WIDTH = vdp_pkg::IdWidthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire vdp_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output vdp_pkg::out_item_t      out_data_o
);
  import vdp_pkg::*;

  // decode state
  logic [ID_WIDTH-1:0]  partial_q, partial_d;
  logic [StepWidth-1:0] step_q, step_d;
  logic [ID_WIDTH-1:0]  prev_id_q, prev_id_d;
  logic                 have_prev_q, have_prev_d;
  logic [31:0]          ids_q, ids_d;
  logic [31:0]          target_q, target_d;
  logic                 err_q, err_d;
  logic                 at_start_q, at_start_d;

  // result register
  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;

  logic in_accept;

  // state as seen by this byte, after a list start has cleared it
  logic [ID_WIDTH-1:0]  partial_cur;
  logic [StepWidth-1:0] step_cur;
  logic                 have_prev_cur;
  logic [31:0]          ids_cur;
  logic [31:0]          target_cur;
  logic                 err_cur;

  logic [ShiftWidth-1:0]  shift_amt;
  logic [ID_WIDTH+63:0]   payload_ext;
  logic [ID_WIDTH-1:0]    partial_new;
  logic [ID_WIDTH-1:0]    id_new;
  logic [ID_WIDTH+31:0]   id_ext;
  logic [31:0]            ids_new;

  // handshake
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // clear on list start
  always_comb begin
    if (at_start_q) begin
      partial_cur   = '0;
      step_cur      = '0;
      have_prev_cur = 1'b0;
      ids_cur       = '0;
      target_cur    = in_data_i.expected_count;
      err_cur       = 1'b0;
    end else begin
      partial_cur   = partial_q;
      step_cur      = step_q;
      have_prev_cur = have_prev_q;
      ids_cur       = ids_q;
      target_cur    = target_q;
      err_cur       = err_q;
    end
  end

  // payload placed at 7 bits per step, bits above the id width dropped
  assign shift_amt   = ShiftWidth'(step_cur) * ShiftStep;
  assign payload_ext = (ID_WIDTH+64)'(in_data_i.data_byte[6:0]) << shift_amt;
  assign partial_new = partial_cur | payload_ext[ID_WIDTH-1:0];
  assign id_new      = have_prev_cur ? (prev_id_q + partial_new) : partial_new;
  assign id_ext      = (ID_WIDTH+32)'(id_new);
  assign ids_new     = ids_cur + 32'd1;

  // single pass decode
  always_comb begin
    partial_d   = partial_cur;
    step_d      = step_cur;
    prev_id_d   = prev_id_q;
    have_prev_d = have_prev_cur;
    ids_d       = ids_cur;
    target_d    = target_cur;
    err_d       = err_cur;
    at_start_d  = in_data_i.last_byte;

    out_data_d.id_valid = 1'b0;
    out_data_d.rec_id   = '0;
    out_data_d.list_end = in_data_i.last_byte;
    out_data_d.status   = StRunning;

    if (err_cur) begin
      out_data_d.status = StDiscard;
    end else if (in_data_i.data_byte[7]) begin
      partial_d = partial_new;
      if (step_cur == MaxSteps) begin
        out_data_d.status = StTooLarge;
        err_d             = 1'b1;
      end else begin
        step_d = step_cur + StepWidth'(1);
        if (in_data_i.last_byte) begin
          out_data_d.status = StTruncated;
          err_d             = 1'b1;
        end
      end
    end else begin
      prev_id_d           = id_new;
      have_prev_d         = 1'b1;
      ids_d               = ids_new;
      partial_d           = '0;
      step_d              = '0;
      out_data_d.id_valid = 1'b1;
      out_data_d.rec_id   = id_ext[31:0];
      if (in_data_i.last_byte) begin
        out_data_d.status = (ids_new == target_cur) ? StOk : StMismatch;
      end
    end
  end

  // decode state, advanced per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      step_q      <= '0;
      prev_id_q   <= '0;
      have_prev_q <= 1'b0;
      ids_q       <= '0;
      target_q    <= '0;
      err_q       <= 1'b0;
      at_start_q  <= 1'b1;
    end else if (in_accept) begin
      partial_q   <= partial_d;
      step_q      <= step_d;
      prev_id_q   <= prev_id_d;
      have_prev_q <= have_prev_d;
      ids_q       <= ids_d;
      target_q    <= target_d;
      err_q       <= err_d;
      at_start_q  <= at_start_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  // checks
  `ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_accept, out_valid_q, "accepted byte gave no result")
  `ASSERT_IMPL(a_id_status, clk_i, rst_ni, out_valid_q && out_data_q.id_valid, out_data_q.status == StRunning || out_data_q.status == StOk || out_data_q.status == StMismatch, "id with error status")
  `ASSERT_IMPL(a_end_status, clk_i, rst_ni, out_valid_q && !out_data_q.list_end, out_data_q.status != StOk && out_data_q.status != StTruncated && out_data_q.status != StMismatch, "list status without list end")
  `ASSERT_IMPL(a_step_range, clk_i, rst_ni, 1'b1, step_q <= MaxSteps, "varint step count beyond shift 63")

endmodule

`default_nettype wire

// ----- verif/varint_delta_posting_decoder_tb.sv -----
// self-checking testbench of varint_delta_posting_decoder: directed table, then random lists
// depends on vdp_pkg and the decoder rtl; a local decoder model predicts every result not fixed by the table
`timescale 1ns / 1ps

module varint_delta_posting_decoder_tb;
  import vdp_pkg::*;

  localparam int unsigned IdBits   = IdWidthDefault;
  localparam int unsigned MaxShift = 63;

  typedef struct {
    in_item_t  stim;
    bit        fixed;
    out_item_t want;
  } table_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // decoder model state, reset values
  logic [IdBits-1:0] partial_acc = '0;
  int unsigned       shift_pos   = 0;
  logic [IdBits-1:0] prev_id     = '0;
  bit                prev_ok     = 1'b0;
  logic [31:0]       id_tally    = '0;
  logic [31:0]       count_goal  = '0;
  bit                err_latched = 1'b0;
  bit                list_start  = 1'b1;

  out_item_t   due_results[$];
  in_item_t    list_bytes[$];
  table_row_t  directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;

  varint_delta_posting_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted result of one accepted byte, advancing the model state
  function automatic out_item_t decode_byte(input in_item_t item);
    out_item_t         res;
    logic [63:0]       wide;
    logic [IdBits-1:0] id;
    if (list_start) begin
      partial_acc = '0;
      shift_pos   = 0;
      prev_ok     = 1'b0;
      id_tally    = '0;
      count_goal  = item.expected_count;
      err_latched = 1'b0;
    end
    list_start   = item.last_byte;
    res          = '0;
    res.list_end = item.last_byte;
    res.status   = StRunning;
    if (err_latched) begin
      res.status = StDiscard;
    end else begin
      // payload bits past the id width are dropped
      if (shift_pos < IdBits) begin
        wide        = 64'(item.data_byte[6:0]) << shift_pos;
        partial_acc = partial_acc | wide[IdBits-1:0];
      end
      if (item.data_byte[7]) begin
        if (shift_pos + ShiftStep > MaxShift) begin
          res.status  = StTooLarge;
          err_latched = 1'b1;
        end else begin
          shift_pos = shift_pos + ShiftStep;
          if (item.last_byte) begin
            res.status  = StTruncated;
            err_latched = 1'b1;
          end
        end
      end else begin
        // first id is absolute, later ones are deltas
        id           = prev_ok ? prev_id + partial_acc : partial_acc;
        prev_id      = id;
        prev_ok      = 1'b1;
        id_tally     = id_tally + 1;
        partial_acc  = '0;
        shift_pos    = 0;
        res.id_valid = 1'b1;
        res.rec_id   = id;
        if (item.last_byte) res.status = (id_tally == count_goal) ? StOk : StMismatch;
      end
    end
    return res;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit last, input logic [31:0] cnt,
                                  input bit fixed, input bit v, input logic [31:0] id,
                                  input status_e st);
    table_row_t row;
    row.stim  = '{data_byte: b, last_byte: last, expected_count: cnt};
    row.fixed = fixed;
    row.want  = '{id_valid: v, rec_id: id, list_end: last, status: st};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // one random list: mostly well formed, some noise, overlong or cut-off varints
  function automatic void queue_list();
    int unsigned kind, n_ids, vlen, pick;
    logic [31:0] goal;
    logic [7:0]  b;
    in_item_t    it;
    kind  = $urandom_range(99);
    n_ids = $urandom_range(6, 1);
    pick  = $urandom_range(9);
    if (pick < 6) goal = n_ids;
    else if (pick < 8) goal = $urandom_range(1) ? n_ids + 1 : n_ids - 1;
    else goal = $urandom();
    if (kind < 10) begin
      repeat ($urandom_range(8, 1))
        list_bytes.insert(list_bytes.size(), '{data_byte: 8'($urandom()), last_byte: 1'b0,
                                               expected_count: $urandom()});
    end else begin
      for (int unsigned i = 0; i < n_ids; i++) begin
        vlen = ($urandom_range(3) == 0) ? $urandom_range(10, 1) : $urandom_range(3, 1);
        for (int unsigned j = 0; j < vlen; j++) begin
          b    = 8'($urandom_range(127));
          b[7] = (j + 1 < vlen);
          list_bytes.insert(list_bytes.size(), '{data_byte: b, last_byte: 1'b0,
                                                 expected_count: $urandom()});
        end
      end
      // overlong varint, then bytes to be discarded
      if (kind < 18) begin
        repeat (10) begin
          b    = 8'($urandom_range(127));
          b[7] = 1'b1;
          list_bytes.insert(list_bytes.size(), '{data_byte: b, last_byte: 1'b0,
                                                 expected_count: $urandom()});
        end
        repeat ($urandom_range(3, 0))
          list_bytes.insert(list_bytes.size(), '{data_byte: 8'($urandom()), last_byte: 1'b0,
                                                 expected_count: $urandom()});
      end else if (kind < 26) begin
        // list cut off inside a varint
        repeat ($urandom_range(3, 1)) begin
          b    = 8'($urandom_range(127));
          b[7] = 1'b1;
          list_bytes.insert(list_bytes.size(), '{data_byte: b, last_byte: 1'b0,
                                                 expected_count: $urandom()});
        end
      end
    end
    it                = list_bytes.pop_front();
    it.expected_count = goal;
    list_bytes.push_front(it);
    it           = list_bytes.pop_back();
    it.last_byte = 1'b1;
    list_bytes.insert(list_bytes.size(), it);
  endfunction

  // drive one byte until its transfer, then queue its expected result
  task automatic send_byte(input in_item_t item, input bit fixed, input out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    pred = decode_byte(item);
    due_results.insert(due_results.size(), fixed ? want : pred);
  endtask

  // hold the input idle until every pending result has arrived
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  function automatic void report(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    mismatches++;
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      $display("%0t: result with no byte pending, expected none, got id %0h status %0d",
               $time, got.rec_id, got.status);
      mismatches++;
    end else begin
      want = due_results.pop_front();
      if (got.id_valid !== want.id_valid)
        report("id_valid", 32'(want.id_valid), 32'(got.id_valid));
      if (got.rec_id !== want.rec_id) report("rec_id", want.rec_id, got.rec_id);
      if (got.list_end !== want.list_end)
        report("list_end", 32'(want.list_end), 32'(got.list_end));
      if (got.status !== want.status) report("status", 32'(want.status), 32'(got.status));
    end
  endfunction

  // result side: check each transfer, stall at the phase rate
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    int unsigned sent;

    phase_idle  = '{0, 80, 0, 35};
    phase_stall = '{0, 0, 80, 35};

    // single-byte list right after reset
    add_row(8'h00, 1'b1, 32'd1, 1, 1'b1, 32'h0, StOk);
    // absolute id then deltas, one of them two bytes long
    add_row(8'h7F, 1'b0, 32'd3, 1, 1'b1, 32'h7F, StRunning);
    add_row(8'h80, 1'b0, 32'hFFFF_FFFF, 0, 1'b0, 32'h0, StRunning);
    add_row(8'h01, 1'b0, 32'h0, 1, 1'b1, 32'hFF, StRunning);
    add_row(8'h05, 1'b1, 32'h0, 1, 1'b1, 32'h104, StOk);
    // count mismatch and cut-off varint
    add_row(8'h01, 1'b1, 32'h0, 1, 1'b1, 32'h1, StMismatch);
    add_row(8'h81, 1'b1, 32'd1, 1, 1'b0, 32'h0, StTruncated);
    // nine continuation bytes reach shift 63, the tenth is too large
    add_row(8'hFF, 1'b0, 32'd5, 0, 1'b0, 32'h0, StRunning);
    repeat (8) add_row(8'hFF, 1'b0, 32'h0, 0, 1'b0, 32'h0, StRunning);
    add_row(8'hFF, 1'b0, 32'h0, 1, 1'b0, 32'h0, StTooLarge);
    add_row(8'h00, 1'b0, 32'h0, 1, 1'b0, 32'h0, StDiscard);
    add_row(8'h00, 1'b1, 32'h0, 1, 1'b0, 32'h0, StDiscard);
    // widest id with dropped high payload bits, then wrap to zero
    add_row(8'hFF, 1'b0, 32'hFFFF_FFFF, 0, 1'b0, 32'h0, StRunning);
    repeat (3) add_row(8'hFF, 1'b0, 32'h0, 0, 1'b0, 32'h0, StRunning);
    add_row(8'h7F, 1'b0, 32'h0, 1, 1'b1, 32'hFFFF_FFFF, StRunning);
    add_row(8'h01, 1'b1, 32'h0, 1, 1'b1, 32'h0, StMismatch);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].want);
    drain_results();

    // random lists under each idle and stall mix
    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      sent      = 0;
      while (sent < 100) begin
        queue_list();
        while (list_bytes.size() != 0) begin
          send_byte(list_bytes.pop_front(), 0, '0);
          sent++;
        end
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
